@@ hw/rtl/probabilistic_cellular_automaton_row_top_macros.svh @@
// assertion macros shared by the row automaton rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef PROBABILISTIC_CELLULAR_AUTOMATON_ROW_TOP_MACROS_SVH
`define PROBABILISTIC_CELLULAR_AUTOMATON_ROW_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define PCA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pca assertion failed");
// condition must never be seen outside reset
`define PCA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("pca forbidden condition seen");
`else
`define PCA_ASSERT(lbl, prop)
`define PCA_ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ hw/rtl/pca_pkg.sv @@
// shared types and constants of the probabilistic automaton row block
// no dependencies
`default_nettype none

package pca_pkg;

  // field widths
  localparam int unsigned ROW_WIDTH_W = 11;
  localparam int unsigned PROB_W      = 16;

  // default line store depth and register reset
  localparam int unsigned       MAX_WIDTH_DEF = 1024;
  localparam int unsigned       ROW_WIDTH_RST = 1024;

  // a probability of all ones always gives a white cell
  localparam logic [PROB_W-1:0] PROB_ALWAYS = 16'hFFFF;

  // item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // neighbour pattern {up-left, up-right} selecting the probability
  typedef enum logic [1:0] {
    NBR_RED   = 2'b00,
    NBR_GREEN = 2'b01,
    NBR_BLUE  = 2'b10,
    NBR_ALPHA = 2'b11
  } pca_nbr_e;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_RD_LAST,
    ST_LD_LAST
  } pca_state_e;

  // control flags from the sequencer to the datapath
  typedef struct packed {
    logic run;       // input transfers allowed
    logic rd_last;   // read the last cell of the row
    logic ld_last;   // capture the last cell register
    logic is_first;  // current column is column 0
    logic is_end;    // current column is the last of the row
  } pca_ctl_t;

  // new cell from probability and random value
  function automatic logic pca_cell(input logic [PROB_W-1:0] prob,
                                    input logic [PROB_W-1:0] rnd);
    return (rnd < prob) || (prob == PROB_ALWAYS);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/probabilistic_cellular_automaton_row_top.sv @@
// Probabilistic automaton row generator. Input channel (in_valid_i/in_ready_o)
// takes one item per transfer: mode 0 loads start_cell at the current column
// and gives no result, mode 1 computes a new cell from the two cells above
// and the random value, and gives one result on the output channel
// (out_valid_o/out_ready_i): cell_res_o and row_end_o for the last column.
// The row width register is written on cfg_valid_i/cfg_ready_o; the user
// must write it only while the block is idle, the block does not enforce
// this. A write restarts the row at column 0. A pixel passes the stage 1
// and output registers. Throughput: one item per cycle while results are
// taken, set by the one write and two reads per item on the line store; a
// same-entry read and write in one cycle is forwarded. After a register
// write the input is not ready while the last row cell is read to a register.
// Reset: column 0, row width 1024, line store contents undefined until
// loaded. A stalled receiver holds the result in the output register and one
// more pixel waits in the compute stage; the input then stops until the
// result is taken.
// depends on pca_pkg, pca_ctrl, pca_line_mem and the assertion macro header
`default_nettype none

`include "probabilistic_cellular_automaton_row_top_macros.svh"

module probabilistic_cellular_automaton_row_top import pca_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [ROW_WIDTH_W-1:0] cfg_data_i,
  // input items
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   mode_i,
  input  wire logic                   start_cell_i,
  input  wire logic [PROB_W-1:0]      prob_red_i,
  input  wire logic [PROB_W-1:0]      prob_green_i,
  input  wire logic [PROB_W-1:0]      prob_blue_i,
  input  wire logic [PROB_W-1:0]      prob_alpha_i,
  input  wire logic [PROB_W-1:0]      random_value_i,
  // results
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic                        cell_res_o,
  output logic                        row_end_o
);

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  pca_ctl_t         ctl;
  logic [COL_W-1:0] col, nxt, last_col;
  logic             in_fire, rd_en;
  logic [COL_W-1:0] raddr_a;
  logic             rdata_a, rdata_b;

  // stage 1 registers
  logic              s1_vld_q, s1_vld_d;
  logic              s1_mode_q, s1_start_q, s1_first_q, s1_end_q;
  logic [COL_W-1:0]  s1_col_q, s1_nxt_q;
  logic [PROB_W-1:0] s1_red_q, s1_green_q, s1_blue_q, s1_alpha_q, s1_rnd_q;
  logic              s1_go;

  // write seen by the reads of the item now in stage 1
  logic              rec_vld_q;
  logic [COL_W-1:0]  rec_addr_q;
  logic              rec_data_q;

  logic              left_above_q, last_q;
  logic              old_cell, right_cell, left_cell, new_cell, wr_cell;
  pca_nbr_e          nbr;
  logic [PROB_W-1:0] prob;

  logic              out_vld_q, out_cell_q, out_end_q;

  pca_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_fire_i  (in_fire),
    .col_o      (col),
    .nxt_o      (nxt),
    .last_col_o (last_col),
    .ctl_o      (ctl)
  );

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ctl.run && (!s1_vld_q || s1_go);
  assign in_fire     = in_valid_i && in_ready_o;
  assign s1_go       = s1_vld_q && ((s1_mode_q == MODE_LOAD) || !out_vld_q || out_ready_i);

  // line store reads: own column and right neighbour, or the last cell
  assign rd_en   = in_fire || ctl.rd_last;
  assign raddr_a = ctl.rd_last ? last_col : col;

  pca_line_mem #(
    .DEPTH(MAX_WIDTH),
    .AW   (COL_W)
  ) u_line_mem (
    .clk_i    (clk_i),
    .we_i     (s1_go),
    .waddr_i  (s1_col_q),
    .wdata_i  (wr_cell),
    .re_i     (rd_en),
    .raddr_a_i(raddr_a),
    .raddr_b_i(nxt),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // stage 1 valid
  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_fire) begin
      s1_vld_d = 1'b1;
    end else if (s1_go) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q  <= mode_i;
      s1_start_q <= start_cell_i;
      s1_red_q   <= prob_red_i;
      s1_green_q <= prob_green_i;
      s1_blue_q  <= prob_blue_i;
      s1_alpha_q <= prob_alpha_i;
      s1_rnd_q   <= random_value_i;
      s1_col_q   <= col;
      s1_nxt_q   <= nxt;
      s1_first_q <= ctl.is_first;
      s1_end_q   <= ctl.is_end;
    end
  end

  // forwarding record of the write that coincided with the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_vld_q <= 1'b0;
    end else if (rd_en) begin
      rec_vld_q <= s1_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rec_addr_q <= s1_col_q;
      rec_data_q <= wr_cell;
    end
  end

  // neighbours with forwarding
  assign old_cell   = (rec_vld_q && (rec_addr_q == s1_col_q)) ? rec_data_q : rdata_a;
  assign right_cell = (rec_vld_q && (rec_addr_q == s1_nxt_q)) ? rec_data_q : rdata_b;
  assign left_cell  = s1_first_q ? last_q : left_above_q;
  assign nbr        = pca_nbr_e'({left_cell, right_cell});

  // probability select and new cell
  always_comb begin
    case (nbr)
      NBR_RED:   prob = s1_red_q;
      NBR_GREEN: prob = s1_green_q;
      NBR_BLUE:  prob = s1_blue_q;
      NBR_ALPHA: prob = s1_alpha_q;
      default:   prob = s1_alpha_q;
    endcase
  end

  assign new_cell = pca_cell(prob, s1_rnd_q);
  assign wr_cell  = (s1_mode_q == MODE_PIXEL) ? new_cell : s1_start_q;

  // up-left cell for the next column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_above_q <= 1'b0;
    end else if (s1_go && (s1_mode_q == MODE_PIXEL)) begin
      left_above_q <= old_cell;
    end
  end

  // copy of the last cell of the row
  always_ff @(posedge clk_i) begin
    if (ctl.ld_last) begin
      last_q <= rdata_a;
    end else if (s1_go && (s1_col_q == last_col)) begin
      last_q <= wr_cell;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_go && (s1_mode_q == MODE_PIXEL)) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && (s1_mode_q == MODE_PIXEL)) begin
      out_cell_q <= new_cell;
      out_end_q  <= s1_end_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign cell_res_o  = out_cell_q;
  assign row_end_o   = out_end_q;

  `PCA_ASSERT(a_no_result_overwrite, s1_go && (s1_mode_q == MODE_PIXEL) |-> !out_vld_q || out_ready_i)
  `PCA_ASSERT(a_row_end_wraps, s1_vld_q && s1_end_q |-> s1_nxt_q == '0)
  `PCA_ASSERT_NEVER(a_refresh_while_busy, ctl.rd_last && s1_vld_q)

endmodule

`default_nettype wire

@@ hw/rtl/pca_line_mem.sv @@
// one-bit line store: one write port, two registered read ports
// no dependencies
`default_nettype none

module pca_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic          wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_a_i,
  input  wire logic [AW-1:0] raddr_b_i,
  output logic               rdata_a_o,
  output logic               rdata_b_o
);

  logic mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read ports, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pca_ctrl.sv @@
// column counter, row width register and last-cell refresh sequencer
// depends on pca_pkg and the assertion macro header
`default_nettype none

`include "probabilistic_cellular_automaton_row_top_macros.svh"

module pca_ctrl import pca_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int unsigned COL_W     = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  input  wire logic [ROW_WIDTH_W-1:0] cfg_data_i,
  input  wire logic                   in_fire_i,
  output logic [COL_W-1:0]            col_o,
  output logic [COL_W-1:0]            nxt_o,
  output logic [COL_W-1:0]            last_col_o,
  output pca_ctl_t                    ctl_o
);

  localparam int unsigned EffRst  = (MAX_WIDTH < ROW_WIDTH_RST) ? MAX_WIDTH : ROW_WIDTH_RST;
  localparam logic [COL_W-1:0] LastColRst = COL_W'(EffRst - 1);

  pca_state_e       state_q, state_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] last_col_q, last_col_d;
  logic             is_end;

  // effective width minus one from the written row width
  always_comb begin
    if (cfg_data_i == '0) begin
      last_col_d = '0;
    end else if (32'(cfg_data_i) > MAX_WIDTH) begin
      last_col_d = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col_d = COL_W'(32'(cfg_data_i) - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= LastColRst;
    end else if (cfg_valid_i) begin
      last_col_q <= last_col_d;
    end
  end

  // column counter with wrap at the row width
  assign is_end = (col_q == last_col_q);
  assign nxt_o  = is_end ? '0 : col_q + 1'b1;

  always_comb begin
    col_d = col_q;
    if (cfg_valid_i) begin
      col_d = '0;
    end else if (in_fire_i) begin
      col_d = nxt_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  // next state: a register write refreshes the last-cell copy
  always_comb begin
    state_d = state_q;
    if (cfg_valid_i) begin
      state_d = ST_RD_LAST;
    end else begin
      case (state_q)
        ST_RUN:     state_d = ST_RUN;
        ST_RD_LAST: state_d = ST_LD_LAST;
        ST_LD_LAST: state_d = ST_RUN;
        default:    state_d = ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // outputs
  always_comb begin
    ctl_o          = '0;
    ctl_o.is_first = (col_q == '0);
    ctl_o.is_end   = is_end;
    case (state_q)
      ST_RUN:     ctl_o.run     = 1'b1;
      ST_RD_LAST: ctl_o.rd_last = 1'b1;
      ST_LD_LAST: ctl_o.ld_last = 1'b1;
      default:    ctl_o.run     = 1'b0;
    endcase
  end

  assign col_o      = col_q;
  assign last_col_o = last_col_q;

  `PCA_ASSERT(a_col_in_row, col_q <= last_col_q)
  `PCA_ASSERT(a_cfg_restarts_row, cfg_valid_i |=> (col_q == '0) && (state_q == ST_RD_LAST))
  `PCA_ASSERT(a_refresh_order, (state_q == ST_RD_LAST) && !cfg_valid_i |=> state_q == ST_LD_LAST)

endmodule

`default_nettype wire

@@ test/tb.sv @@
// testbench for the probabilistic automaton row block: directed rows, then random phases
// predicts cells without a typed-in result from its own copy of the line store, column and row width
// depends on pca_pkg and probabilistic_cellular_automaton_row_top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pca_pkg::*;

  localparam int unsigned MAX_W = MAX_WIDTH_DEF;

  // one pixel or load item, and one produced cell
  typedef struct packed {
    logic              mode;
    logic              start_cell;
    logic [PROB_W-1:0] red, green, blue, alpha, rnd;
  } pix_item_t;

  typedef struct packed {
    logic cell_res;
    logic row_end;
  } pix_res_t;

  // directed row: either a width write or an item, optionally with a typed-in result
  typedef struct packed {
    logic                   is_cfg;
    logic [ROW_WIDTH_W-1:0] width;
    pix_item_t              it;
    logic                   typed;
    pix_res_t               want;
  } plan_row_t;

  localparam logic ROW_CFG   = 1'b1;
  localparam logic ROW_ITEM  = 1'b0;
  localparam logic CHK_TYPED = 1'b1;
  localparam logic CHK_MODEL = 1'b0;

  localparam plan_row_t PLAN [24] = '{
    // four-wide row: load 1 0 1 1, ignored fields all ones, zeros, mixed, then zeros
    '{ROW_CFG, 11'd4, '{MODE_LOAD, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_LOAD, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_LOAD, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_LOAD, 1'b1, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F},
      CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_LOAD, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, CHK_MODEL, 2'b00},
    // always-white and never-white probabilities
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      CHK_TYPED, '{1'b1, 1'b0}},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
      CHK_TYPED, '{1'b0, 1'b0}},
    // distinct probabilities show which neighbour pattern was used
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b0, 16'h8000, 16'h4000, 16'h2000, 16'h1000, 16'h0FFF},
      CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b1, 16'h8000, 16'h4000, 16'h2000, 16'h1000, 16'h3FFF},
      CHK_MODEL, 2'b00},
    // random value at and just below the probability
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b0, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0000},
      CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b0, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0001},
      CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b0, 16'h0002, 16'h0002, 16'h0003, 16'h0003, 16'h0002},
      CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b1, 16'hFFFE, 16'hFFFE, 16'hFFFF, 16'hFFFE, 16'hFFFD},
      CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b0, 16'hFFFE, 16'h7FFF, 16'hFFFE, 16'h8000, 16'hFFFE},
      CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b1, 16'h0000, 16'hFFFF, 16'h8001, 16'h0000, 16'h8000},
      CHK_MODEL, 2'b00},
    // one-wide row: both neighbours are the old cell itself
    '{ROW_CFG, 11'd1, '{MODE_LOAD, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_LOAD, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000},
      CHK_TYPED, '{1'b1, 1'b1}},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF},
      CHK_TYPED, '{1'b0, 1'b1}},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hC000, 16'hA000},
      CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b0, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'hA000},
      CHK_MODEL, 2'b00},
    // zero width acts as one
    '{ROW_CFG, 11'd0, '{MODE_LOAD, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b1, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h3FFF},
      CHK_MODEL, 2'b00},
    '{ROW_ITEM, 11'd0, '{MODE_PIXEL, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      CHK_TYPED, '{1'b1, 1'b1}}
  };

  // random phases: row width and item count, the last one runs without idling
  localparam int NUM_PHASES  = 11;
  localparam int SQUEEZE_PH  = 5;
  localparam logic [ROW_WIDTH_W-1:0] PH_WIDTH [NUM_PHASES] = '{
    11'd1024, 11'd1, 11'd2, 11'd3, 11'd5, 11'd16, 11'd0, 11'd2047, 11'd1023, 11'd7, 11'd33
  };
  localparam int PH_ITEMS [NUM_PHASES] = '{
    250, 60, 80, 100, 120, 200, 40, 60, 60, 60, 60
  };

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   cfg_valid_i    = 1'b0;
  logic                   cfg_ready_o;
  logic [ROW_WIDTH_W-1:0] cfg_data_i     = '0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_ready_o;
  logic                   mode_i         = MODE_LOAD;
  logic                   start_cell_i   = 1'b0;
  logic [PROB_W-1:0]      prob_red_i     = '0;
  logic [PROB_W-1:0]      prob_green_i   = '0;
  logic [PROB_W-1:0]      prob_blue_i    = '0;
  logic [PROB_W-1:0]      prob_alpha_i   = '0;
  logic [PROB_W-1:0]      random_value_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i    = 1'b1;
  logic                   cell_res_o;
  logic                   row_end_o;

  // own copy of the block state
  bit                     cell_mem  [MAX_W];
  bit                     cell_seen [MAX_W];
  int unsigned            col_q     = 0;
  bit                     left_q    = 1'b0;
  logic [ROW_WIDTH_W-1:0] width_q   = ROW_WIDTH_W'(ROW_WIDTH_RST);

  pix_res_t cells_due [$];
  int       errors  = 0;
  bit       calm    = 1'b0;
  bit       squeeze = 1'b0;

  always #5 clk_i = ~clk_i;

  probabilistic_cellular_automaton_row_top #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .start_cell_i,
    .prob_red_i,
    .prob_green_i,
    .prob_blue_i,
    .prob_alpha_i,
    .random_value_i,
    .out_valid_o,
    .out_ready_i,
    .cell_res_o,
    .row_end_o
  );

  // row width as the block uses it
  function automatic int unsigned eff_width();
    int unsigned w;
    w = 32'(width_q);
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  // advance the row by one item, gives 1 and the new cell for a pixel
  function automatic bit advance_row(input pix_item_t it, output pix_res_t r);
    int unsigned       w;
    int unsigned       c;
    int unsigned       nx;
    pca_nbr_e          nbr;
    logic [PROB_W-1:0] p;
    w  = eff_width();
    c  = (col_q >= w) ? 0 : col_q;
    nx = (c + 1 >= w) ? 0 : c + 1;
    r  = '0;
    if (it.mode == MODE_LOAD) begin
      cell_mem[c]  = it.start_cell;
      cell_seen[c] = 1'b1;
      col_q        = nx;
      return 1'b0;
    end
    nbr = pca_nbr_e'({(c == 0) ? cell_mem[w-1] : left_q, cell_mem[nx]});
    case (nbr)
      NBR_RED:   p = it.red;
      NBR_GREEN: p = it.green;
      NBR_BLUE:  p = it.blue;
      default:   p = it.alpha;
    endcase
    r.cell_res  = (it.rnd < p) || (p == PROB_ALWAYS);
    r.row_end   = (c == w - 1);
    left_q      = cell_mem[c];
    cell_mem[c] = r.cell_res;
    col_q       = nx;
    return 1'b1;
  endfunction

  // probabilities lean on the edges of the range
  function automatic logic [PROB_W-1:0] pick_prob();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PROB_ALWAYS;
      2:       return PROB_ALWAYS - 1'b1;
      default: return PROB_W'($urandom);
    endcase
  endfunction

  // next random item, a load wherever a pixel would read a cell never written
  function automatic pix_item_t pick_item(input bit want_load);
    pix_item_t         it;
    logic [PROB_W-1:0] p4 [4];
    int unsigned       w;
    int unsigned       c;
    int unsigned       nx;
    bit                legal;
    w     = eff_width();
    c     = (col_q >= w) ? 0 : col_q;
    nx    = (c + 1 >= w) ? 0 : c + 1;
    legal = cell_seen[c] && cell_seen[nx] && (c != 0 || cell_seen[w-1]);
    for (int k = 0; k < 4; k++) p4[k] = pick_prob();
    it.red        = p4[0];
    it.green      = p4[1];
    it.blue       = p4[2];
    it.alpha      = p4[3];
    it.start_cell = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0, 1:    it.rnd = p4[$urandom_range(0, 3)];
      2:       it.rnd = p4[$urandom_range(0, 3)] - 1'b1;
      default: it.rnd = PROB_W'($urandom);
    endcase
    it.mode = (legal && !want_load && $urandom_range(0, 99) >= 12) ? MODE_PIXEL : MODE_LOAD;
    return it;
  endfunction

  // offer one item until its transfer, then record what it should produce
  task automatic send_item(input pix_item_t it, input logic typed, input pix_res_t typed_res);
    pix_res_t r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    mode_i         <= it.mode;
    start_cell_i   <= it.start_cell;
    prob_red_i     <= it.red;
    prob_green_i   <= it.green;
    prob_blue_i    <= it.blue;
    prob_alpha_i   <= it.alpha;
    random_value_i <= it.rnd;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (advance_row(it, r)) cells_due.push_back(typed ? typed_res : r);
  endtask

  // stop offering and wait until the block has nothing left in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // row width write, only while idle
  task automatic write_width(input logic [ROW_WIDTH_W-1:0] wv);
    cfg_data_i  <= wv;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    width_q = wv;
    col_q   = 0;
  endtask

  task automatic flag_bad(input string what, input logic want_v, input logic got_v);
    errors++;
    if (errors <= 10) $display("tb: mismatch on %s, expected %0b, got %0b", what, want_v, got_v);
  endtask

  // result side: compare each transfer with the oldest expected cell
  always @(posedge clk_i) begin : watch_cells
    pix_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cells_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: result transfer with nothing outstanding");
      end else begin
        want = cells_due.pop_front();
        if (cell_res_o !== want.cell_res) flag_bad("cell_res", want.cell_res, cell_res_o);
        if (row_end_o !== want.row_end) flag_bad("row_end", want.row_end, row_end_o);
      end
    end
  end

  // receiver stalls, with one long hold-off while items keep coming
  initial begin : result_ready
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (squeeze && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        for (int k = 0; k < 120; k++) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  // main sequence: reset, directed rows, random phases, drain
  initial begin : stimulus
    pix_item_t it;
    int        w;
    bit        reload;
    int        guard;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PLAN[i]) begin
      if (PLAN[i].is_cfg) begin
        settle();
        write_width(PLAN[i].width);
      end else begin
        send_item(PLAN[i].it, PLAN[i].typed, PLAN[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_width(PH_WIDTH[ph]);
      if (ph == NUM_PHASES - 1) calm = 1'b1;
      if (ph == SQUEEZE_PH) squeeze = 1'b1;
      w      = eff_width();
      // narrow rows sometimes start with a full row of starting cells
      reload = (w <= 64) && ($urandom_range(0, 1) == 1);
      for (int n = 0; n < PH_ITEMS[ph]; n++) begin
        it = pick_item(reload && n < w);
        send_item(it, CHK_MODEL, '0);
      end
    end

    in_valid_i <= 1'b0;
    for (guard = 0; guard < 5000 && cells_due.size() != 0; guard++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (cells_due.size() != 0) begin
      errors++;
      $display("tb: %0d expected cells never arrived", cells_due.size());
    end
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
